@@ rtl/pft_pkg.sv @@
package pft_pkg;

    localparam int unsigned FRONT_DEPTH_DEF = 64;
    localparam int unsigned COST_WIDTH_DEF  = 32;
    localparam int unsigned ERROR_WIDTH_DEF = 32;

    // fixed port widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned TOTAL_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

endpackage

@@ rtl/pft_mem.sv @@
module pft_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/pareto_front_table.sv @@
// two-objective pareto front held in one synchronous ram (cost and error side by side),
// sorted by rising cost with strictly falling error. each request gives exactly one
// response. a request is a walk over the ram with one registered read port:
// the lookup reads entries from the bottom until the first cost above the asked cost,
// an accepted add then reads on past the insert point over the entries it dominates,
// moves the surviving tail up by one or down over the gap and writes the new point.
// a clear or an unused code does not walk the ram.
// one request is worked on at a time; a new request is taken while the previous
// response still waits in the output register. when an insert leaves more than
// FRONT_DEPTH entries the highest-cost one is dropped and overflow is reported
module pareto_front_table #(
    parameter int unsigned FRONT_DEPTH = pft_pkg::FRONT_DEPTH_DEF,
    parameter int unsigned COST_WIDTH  = pft_pkg::COST_WIDTH_DEF,
    parameter int unsigned ERROR_WIDTH = pft_pkg::ERROR_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [pft_pkg::CMD_W-1:0]    cmd,
    input  logic [pft_pkg::FIELD_W-1:0]  cost,
    input  logic [pft_pkg::FIELD_W-1:0]  error_value,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         found,
    output logic [pft_pkg::FIELD_W-1:0]  best_error,
    output logic                         accepted,
    output logic                         overflow,
    output logic [pft_pkg::TOTAL_W-1:0]  entry_total
);

    import pft_pkg::*;

    localparam int unsigned AW = $clog2(FRONT_DEPTH);
    localparam int unsigned CW = $clog2(FRONT_DEPTH + 2);
    localparam int unsigned MW = COST_WIDTH + ERROR_WIDTH;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SRCH_RD  = 11'b00000000010,
        S_SRCH_CMP = 11'b00000000100,
        S_DECIDE   = 11'b00000001000,
        S_DOM_RD   = 11'b00000010000,
        S_DOM_CMP  = 11'b00000100000,
        S_SETUP    = 11'b00001000000,
        S_MOVE_RD  = 11'b00010000000,
        S_MOVE_WR  = 11'b00100000000,
        S_NEW_WR   = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // request held for the whole walk
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [COST_WIDTH-1:0]  c_reg, c_next;
    logic [ERROR_WIDTH-1:0] e_reg, e_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // search index, dominance index, move source
    logic [CW-1:0] p_reg, p_next;         // entries with cost not above c
    logic [CW-1:0] q_reg, q_next;         // first surviving entry after the insert point
    logic [CW-1:0] pos_reg, pos_next;     // slot of the new point
    logic [CW-1:0] dst_reg, dst_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] total_reg, total_next;
    logic          desc_reg, desc_next;

    logic                   hit_reg, hit_next;
    logic [ERROR_WIDTH-1:0] best_reg, best_next;
    logic [COST_WIDTH-1:0]  hit_cost_reg, hit_cost_next;
    logic                   acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;

    // output register
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   found_reg, found_next;
    logic [FIELD_W-1:0]     best_out_reg, best_out_next;
    logic                   accepted_reg, accepted_next;
    logic                   overflow_reg, overflow_next;
    logic [TOTAL_W-1:0]     total_out_reg, total_out_next;

    // ram port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] rd_data;

    logic [COST_WIDTH-1:0]  rd_cost;
    logic [ERROR_WIDTH-1:0] rd_err;

    logic [COST_WIDTH+FIELD_W-1:0]  cost_ext;
    logic [ERROR_WIDTH+FIELD_W-1:0] err_ext;
    logic [ERROR_WIDTH+FIELD_W-1:0] best_ext;
    logic [CW+TOTAL_W-1:0]          count_ext;

    logic          req_take;
    logic          rsp_free;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] tail_n;

    pft_mem #(
        .DEPTH (FRONT_DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_cost = rd_data[MW-1:ERROR_WIDTH];
    assign rd_err  = rd_data[ERROR_WIDTH-1:0];

    // fields are taken in their low bits
    assign cost_ext = (COST_WIDTH + FIELD_W)'(cost);
    assign err_ext  = (ERROR_WIDTH + FIELD_W)'(error_value);
    assign best_ext = (ERROR_WIDTH + FIELD_W)'(best_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign idx_inc   = idx_reg + CW'(1);
    assign tail_n    = count_reg - q_reg;

    // ram read address follows the walk
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        c_next        = c_reg;
        e_next        = e_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        pos_next      = pos_reg;
        dst_next      = dst_reg;
        left_next     = left_reg;
        total_next    = total_reg;
        desc_next     = desc_reg;
        hit_next      = hit_reg;
        best_next     = best_reg;
        hit_cost_next = hit_cost_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        found_next     = found_reg;
        best_out_next  = best_out_reg;
        accepted_next  = accepted_reg;
        overflow_next  = overflow_reg;
        total_out_next = total_out_reg;
        count_ext      = (CW + TOTAL_W)'(count_reg);

        wr_en   = 1'b0;
        wr_addr = dst_reg[AW-1:0];
        wr_data = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    cmd_next = cmd;
                    c_next   = cost_ext[COST_WIDTH-1:0];
                    e_next   = err_ext[ERROR_WIDTH-1:0];
                    hit_next = 1'b0;
                    acc_next = 1'b0;
                    ovf_next = 1'b0;
                    p_next   = '0;
                    idx_next = '0;
                    unique case (cmd) inside
                        CMD_ADD, CMD_QUERY:
                        begin
                            state_next = (count_reg == '0) ? S_DECIDE : S_SRCH_RD;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (rd_cost <= c_reg)
                begin
                    hit_next      = 1'b1;
                    best_next     = rd_err;
                    hit_cost_next = rd_cost;
                    p_next        = idx_inc;
                    if (idx_inc < count_reg)
                    begin
                        idx_next   = idx_inc;
                        state_next = S_SRCH_RD;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if ((cmd_reg != CMD_ADD) || (hit_reg && !(e_reg < best_reg)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next = 1'b1;
                    pos_next = (hit_reg && (hit_cost_reg == c_reg)) ? p_reg - CW'(1) : p_reg;
                    idx_next = p_reg;
                    if (p_reg < count_reg)
                    begin
                        state_next = S_DOM_RD;
                    end
                    else
                    begin
                        q_next     = p_reg;
                        state_next = S_SETUP;
                    end
                end
            end

            S_DOM_RD:
            begin
                state_next = S_DOM_CMP;
            end

            S_DOM_CMP:
            begin
                if (rd_err >= e_reg)
                begin
                    if (idx_inc < count_reg)
                    begin
                        idx_next   = idx_inc;
                        state_next = S_DOM_RD;
                    end
                    else
                    begin
                        q_next     = count_reg;
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    q_next     = idx_reg;
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                total_next = pos_reg + CW'(1) + tail_n;
                left_next  = tail_n;
                if ((tail_n == '0) || (pos_reg + CW'(1) == q_reg))
                begin
                    state_next = S_NEW_WR;
                end
                else if (pos_reg + CW'(1) > q_reg)
                begin
                    // tail moves up by one: copy from the top down
                    desc_next  = 1'b1;
                    idx_next   = count_reg - CW'(1);
                    dst_next   = count_reg;
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    // tail closes the gap of the removed entries: copy upwards
                    desc_next  = 1'b0;
                    idx_next   = q_reg;
                    dst_next   = pos_reg + CW'(1);
                    state_next = S_MOVE_RD;
                end
            end

            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // an entry pushed past the top is dropped
                wr_en     = (dst_reg < CW'(FRONT_DEPTH));
                wr_addr   = dst_reg[AW-1:0];
                wr_data   = rd_data;
                left_next = left_reg - CW'(1);
                idx_next  = desc_reg ? idx_reg - CW'(1) : idx_inc;
                dst_next  = desc_reg ? dst_reg - CW'(1) : dst_reg + CW'(1);
                state_next = (left_reg == CW'(1)) ? S_NEW_WR : S_MOVE_RD;
            end

            S_NEW_WR:
            begin
                wr_en   = (pos_reg < CW'(FRONT_DEPTH));
                wr_addr = pos_reg[AW-1:0];
                wr_data = {c_reg, e_reg};
                if (total_reg > CW'(FRONT_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    count_next = CW'(FRONT_DEPTH);
                end
                else
                begin
                    count_next = total_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = hit_reg;
                    best_out_next  = hit_reg ? best_ext[FIELD_W-1:0] : '1;
                    accepted_next  = acc_reg;
                    overflow_next  = ovf_reg;
                    total_out_next = count_ext[TOTAL_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        c_reg         <= c_next;
        e_reg         <= e_next;
        idx_reg       <= idx_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        pos_reg       <= pos_next;
        dst_reg       <= dst_next;
        left_reg      <= left_next;
        total_reg     <= total_next;
        desc_reg      <= desc_next;
        hit_reg       <= hit_next;
        best_reg      <= best_next;
        hit_cost_reg  <= hit_cost_next;
        acc_reg       <= acc_next;
        ovf_reg       <= ovf_next;
        found_reg     <= found_next;
        best_out_reg  <= best_out_next;
        accepted_reg  <= accepted_next;
        overflow_reg  <= overflow_next;
        total_out_reg <= total_out_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign best_error  = best_out_reg;
    assign accepted    = accepted_reg;
    assign overflow    = overflow_reg;
    assign entry_total = total_out_reg;

endmodule
